>>> sv/bpscf_pkg.sv
// ----------------------------------------------------------------------------
// bpscf_pkg
// Shared constants and types of the box plane set cull filter: field widths,
// stream bit positions, register indexes and request kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package bpscf_pkg;

  localparam int MAX_PLANES_DEF = 16;

  localparam int FIX_W   = 32;
  localparam int SIZE_W  = 31;
  localparam int TAG_W   = 16;
  localparam int SLOT_W  = 4;
  localparam int CNT_W   = 5;

  // Stretched corner, product and partial sum widths of the plane test.
  localparam int POS_W   = FIX_W + 1;
  localparam int PROD_W  = FIX_W + POS_W;
  localparam int DOFF_W  = FIX_W + 17;
  localparam int PSUM_W  = PROD_W + 1;
  localparam int TOT_W   = PSUM_W + 1;

  // Input stream data layout, lowest field first.
  localparam int IN_SLOT_LO = 0;
  localparam int IN_X_LO    = IN_SLOT_LO + SLOT_W;
  localparam int IN_Y_LO    = IN_X_LO + FIX_W;
  localparam int IN_Z_LO    = IN_Y_LO + FIX_W;
  localparam int IN_SX_LO   = IN_Z_LO + FIX_W;
  localparam int IN_SY_LO   = IN_SX_LO + SIZE_W;
  localparam int IN_SZ_LO   = IN_SY_LO + SIZE_W;
  localparam int IN_OFF_LO  = IN_SZ_LO + SIZE_W;
  localparam int IN_TAG_LO  = IN_OFF_LO + FIX_W;
  localparam int IN_BITS    = IN_TAG_LO + TAG_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;

  // Output stream data layout, lowest field first.
  localparam int OUT_TAG_LO = 0;
  localparam int OUT_KEEP   = OUT_TAG_LO + TAG_W;
  localparam int OUT_BITS   = OUT_KEEP + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_PLANE_COUNT   = 2'd0,
    REG_LIGHT_OOR     = 2'd1,
    REG_CULLER_ACTIVE = 2'd2
  } reg_idx_t;

  typedef enum logic {
    CMD_PLANE = 1'b0,
    CMD_BOX   = 1'b1
  } cmd_t;

endpackage

`default_nettype wire

>>> sv/box_plane_set_cull_filter.sv
// ----------------------------------------------------------------------------
// box_plane_set_cull_filter
// Tests axis-aligned boxes against a table of up to MAX_PLANES culling planes
// and returns a keep flag with the tag of each box.
// ----------------------------------------------------------------------------
// A plane request (tuser low) writes one slot of the plane table in the cycle
// it is accepted and gives no result. A box request (tuser high) is tested
// against the first plane_count slots in parallel, one lane per slot with
// three multipliers each. One box can be accepted every cycle; a stalled
// output fills the five pipeline stages before the input stalls. Results
// leave on m_tvalid in request order. An inactive culler keeps every box;
// otherwise a set light_out_of_range culls every box. A box sees every plane
// written by requests accepted before it. Slots must be written before they
// take part in a test.
`default_nettype none

module box_plane_set_cull_filter #(
  parameter int MAX_PLANES = bpscf_pkg::MAX_PLANES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Plane and box requests.
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // slot, norm_or_corner_x, norm_or_corner_y, norm_or_corner_z, size_x,
  // size_y, size_z, plane_offset, tag, zero padding
  input  wire logic [bpscf_pkg::IN_DATA_W-1:0]     s_tdata,
  // cmd
  input  wire logic                                s_tuser,
  input  wire logic                                s_tlast,
  // Results.
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // tag_out, keep, zero padding
  output logic [bpscf_pkg::OUT_DATA_W-1:0]         m_tdata,
  output logic                                     m_tlast,
  // Configuration.
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [bpscf_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [bpscf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bpscf_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                     pready
);

  import bpscf_pkg::*;

  // Configuration registers.
  logic [CNT_W-1:0] plane_count;
  logic             light_out_of_range;
  logic             culler_active;
  reg_idx_t         reg_idx;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_count        <= '0;
      light_out_of_range <= 1'b0;
      culler_active      <= 1'b1;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_PLANE_COUNT:   plane_count        <= pwdata[CNT_W-1:0];
        REG_LIGHT_OOR:     light_out_of_range <= pwdata[0];
        REG_CULLER_ACTIVE: culler_active      <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_PLANE_COUNT:   prdata = APB_DATA_W'(plane_count);
      REG_LIGHT_OOR:     prdata = APB_DATA_W'(light_out_of_range);
      REG_CULLER_ACTIVE: prdata = APB_DATA_W'(culler_active);
      default:           prdata = '0;
    endcase
  end

  // Input field unpacking.
  logic [SLOT_W-1:0]       in_slot;
  logic signed [FIX_W-1:0] in_v   [3];
  logic [SIZE_W-1:0]       in_sz  [3];
  logic signed [FIX_W-1:0] in_off;
  logic [TAG_W-1:0]        in_tag;
  cmd_t                    in_cmd;

  assign in_slot  = s_tdata[IN_SLOT_LO +: SLOT_W];
  assign in_v[0]  = s_tdata[IN_X_LO +: FIX_W];
  assign in_v[1]  = s_tdata[IN_Y_LO +: FIX_W];
  assign in_v[2]  = s_tdata[IN_Z_LO +: FIX_W];
  assign in_sz[0] = s_tdata[IN_SX_LO +: SIZE_W];
  assign in_sz[1] = s_tdata[IN_SY_LO +: SIZE_W];
  assign in_sz[2] = s_tdata[IN_SZ_LO +: SIZE_W];
  assign in_off   = s_tdata[IN_OFF_LO +: FIX_W];
  assign in_tag   = s_tdata[IN_TAG_LO +: TAG_W];
  assign in_cmd   = cmd_t'(s_tuser);

  // Pipeline control.
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic in_fire;
  logic plane_fire;
  logic box_fire;

  assign rdy5       = !v5 || m_tready;
  assign rdy4       = !v4 || rdy5;
  assign rdy3       = !v3 || rdy4;
  assign rdy2       = !v2 || rdy3;
  assign rdy1       = !v1 || rdy2;
  assign s_tready   = rdy1;
  assign in_fire    = s_tvalid && s_tready;
  assign plane_fire = in_fire && (in_cmd == CMD_PLANE);
  assign box_fire   = in_fire && (in_cmd == CMD_BOX);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= box_fire;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // Plane table, one entry per lane.
  logic signed [FIX_W-1:0] tab_n [MAX_PLANES][3];
  logic signed [FIX_W-1:0] tab_d [MAX_PLANES];

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_PLANES; k++) begin
      if (plane_fire && (int'(in_slot) == k)) begin
        for (int i = 0; i < 3; i++) begin
          tab_n[k][i] <= in_v[i];
        end
        tab_d[k] <= in_off;
      end
    end
  end

  // Stage 1: plane operands and the box corner nearest the negative side.
  logic signed [FIX_W-1:0] n1  [MAX_PLANES][3];
  logic signed [POS_W-1:0] p1  [MAX_PLANES][3];
  logic signed [FIX_W-1:0] d1  [MAX_PLANES];
  logic signed [POS_W-1:0] pos_lo [3];
  logic signed [POS_W-1:0] pos_hi [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_lo[i] = POS_W'(in_v[i]);
      pos_hi[i] = pos_lo[i] + $signed({2'b00, in_sz[i]});
    end
  end

  // Stage 2: products and the widened offset.
  logic signed [PROD_W-1:0] prod2 [MAX_PLANES][3];
  logic signed [DOFF_W-1:0] dn2   [MAX_PLANES];
  // Stage 3: partial sums.
  logic signed [PSUM_W-1:0] sa3   [MAX_PLANES];
  logic signed [PSUM_W-1:0] sb3   [MAX_PLANES];
  // Stage 4: per-plane reject.
  logic [MAX_PLANES-1:0]    rej4;
  logic signed [TOT_W-1:0]  tot   [MAX_PLANES];
  // Stage 5: keep flag.
  logic                     keep5;
  logic                     keep_next;
  logic [MAX_PLANES-1:0]    lane_on;

  logic [TAG_W-1:0] tag1, tag2, tag3, tag4, tag5;
  logic             last1, last2, last3, last4, last5;

  always_comb begin
    for (int k = 0; k < MAX_PLANES; k++) begin
      tot[k]     = TOT_W'(sa3[k]) + TOT_W'(sb3[k]);
      lane_on[k] = (k < int'(plane_count));
    end
    if (!culler_active) begin
      keep_next = 1'b1;
    end else if (light_out_of_range) begin
      keep_next = 1'b0;
    end else begin
      keep_next = !(|(rej4 & lane_on));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int k = 0; k < MAX_PLANES; k++) begin
        for (int i = 0; i < 3; i++) begin
          n1[k][i] <= tab_n[k][i];
          p1[k][i] <= tab_n[k][i][FIX_W-1] ? pos_hi[i] : pos_lo[i];
        end
        d1[k] <= tab_d[k];
      end
      tag1  <= in_tag;
      last1 <= s_tlast;
    end
    if (rdy2) begin
      for (int k = 0; k < MAX_PLANES; k++) begin
        for (int i = 0; i < 3; i++) begin
          prod2[k][i] <= n1[k][i] * p1[k][i];
        end
        dn2[k] <= -$signed({d1[k][FIX_W-1], d1[k], 16'h0000});
      end
      tag2  <= tag1;
      last2 <= last1;
    end
    if (rdy3) begin
      for (int k = 0; k < MAX_PLANES; k++) begin
        sa3[k] <= PSUM_W'(prod2[k][0]) + PSUM_W'(prod2[k][1]);
        sb3[k] <= PSUM_W'(prod2[k][2]) + PSUM_W'(dn2[k]);
      end
      tag3  <= tag2;
      last3 <= last2;
    end
    if (rdy4) begin
      for (int k = 0; k < MAX_PLANES; k++) begin
        rej4[k] <= (tot[k] > $signed(TOT_W'(0)));
      end
      tag4  <= tag3;
      last4 <= last3;
    end
    if (rdy5) begin
      keep5 <= keep_next;
      tag5  <= tag4;
      last5 <= last4;
    end
  end

  always_comb begin
    m_tdata                          = '0;
    m_tdata[OUT_TAG_LO +: TAG_W]     = tag5;
    m_tdata[OUT_KEEP]                = keep5;
  end

  assign m_tvalid = v5;
  assign m_tlast  = last5;

  // A held first stage keeps its box while the next stage is full.
  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !rdy2 |=> v1 && $stable(tag1))
    else $error("first stage lost or changed a box while held");

  // Plane requests never enter the result pipeline.
  a_plane_no_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_PLANE) |=> !v1)
    else $error("plane request produced a pipeline entry");

  // The input only stalls when every stage holds a box.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> v1 && v2 && v3 && v4 && v5)
    else $error("input stalled with an empty stage");

endmodule

`default_nettype wire
